### hdl/amdc_pkg.sv
// shared types, constants and saturating arithmetic of the motor duty controller
`default_nettype none

package amdc_pkg;

  localparam int QW = 48;
  localparam int FRAC_BITS_DEF = 32;

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic        speed_valid;
    logic [15:0] speed_target;
    logic [4:0]  steer_position;
    logic [15:0] measured_speed;
  } amdc_in_t;

  typedef struct packed {
    logic [6:0] motor_duty;
    logic       rolled_back;
  } amdc_out_t;

  typedef enum logic [0:0] {
    REG_USE_NEURON  = 1'b0,
    REG_NO_FEEDBACK = 1'b1
  } amdc_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DSP,
    ST_DRF,
    ST_DERR,
    ST_SIG1,
    ST_SIG2,
    ST_SIGF,
    ST_EE,
    ST_AD1,
    ST_AD2,
    ST_OUT
  } amdc_state_t;

  typedef enum logic [1:0] {
    PS_BEFORE,
    PS_AFTER,
    PS_FINAL
  } amdc_pass_t;

  function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? Q_MIN : Q_MAX;
    return s[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? Q_MIN : Q_MAX;
    return s[QW-1:0];
  endfunction

  // weight times a small steer offset, saturated
  function automatic logic signed [QW-1:0] sat_mul_small(input logic signed [QW-1:0] w,
                                                         input logic [3:0] k);
    logic signed [QW+4:0] we;
    logic signed [QW+4:0] ke;
    logic signed [QW+4:0] p;
    we = {{5{w[QW-1]}}, w};
    ke = {{(QW+1){1'b0}}, k};
    p = we * ke;
    if (p[QW+4:QW-1] != {6{1'b0}} && p[QW+4:QW-1] != {6{1'b1}})
      return p[QW+4] ? Q_MIN : Q_MAX;
    return p[QW-1:0];
  endfunction

endpackage

`default_nettype wire

### hdl/adaptive_motor_duty_controller.sv
// adaptive motor duty controller: sequencer with serial divider and serial multiplier
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall  | amdc_in_t
//   out_    | output    | out_valid/out_stall| amdc_out_t
//   cfg_    | input     | cfg_we             | cfg_idx, cfg_wdata
//
// one transaction at a time; the input stalls from acceptance until the result is registered.
// each divide is by 1000 and each multiply is shift-add.
// message without speed: 3 divides + 2 multiplies; with speed: 3 divides
// + 7 multiplies; a rollback adds 3 divides + 2 multiplies.
// synchronous active-low reset clears weights, stored speed and control state.
// a result waiting on out_stall does not block the next input transaction.
`default_nettype none

module adaptive_motor_duty_controller #(
  parameter int FRAC_BITS = amdc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire amdc_pkg::amdc_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output amdc_pkg::amdc_out_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_idx,
  input  wire logic                cfg_wdata
);
  import amdc_pkg::*;

  localparam int DSTEPS = 16 + FRAC_BITS;
  localparam int MSTEPS = QW;
  localparam int CW = $clog2(DSTEPS + 1);
  localparam logic [CW-1:0] DEND = CW'(DSTEPS);
  localparam logic [CW-1:0] MEND = CW'(MSTEPS);
  localparam logic signed [QW-1:0] QONE = QW'(64'd1 << FRAC_BITS);
  localparam logic signed [QW-1:0] QEPS = QW'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  amdc_state_t state_r, state_nxt;
  amdc_pass_t  pass_r, pass_nxt;

  logic use_neuron_r, no_feedback_r;

  // weights and stored speed, plus the copies kept for rollback
  logic [15:0] ss_r, ss_nxt, sv_ss_r, sv_ss_nxt;
  logic signed [QW-1:0] wb_r, wb_nxt, wl_r, wl_nxt, wr_r, wr_nxt;
  logic signed [QW-1:0] ws_r, ws_nxt, wt_r, wt_nxt, es_r, es_nxt;
  logic signed [QW-1:0] sv_b_r, sv_b_nxt, sv_l_r, sv_l_nxt, sv_r_r, sv_r_nxt;
  logic signed [QW-1:0] sv_s_r, sv_s_nxt, sv_t_r, sv_t_nxt, sv_e_r, sv_e_nxt;

  // current transaction
  logic        vld_r, vld_nxt;
  logic [15:0] ref_r, ref_nxt;
  logic [4:0]  steer_r, steer_nxt;
  logic        rolled_r, rolled_nxt;

  // scaled operands and signal values
  logic signed [QW-1:0] sp_r, sp_nxt, rf_r, rf_nxt, err_r, err_nxt, ee_r, ee_nxt;
  logic signed [QW-1:0] vacc_r, vacc_nxt, before_r, before_nxt, fin_r, fin_nxt;

  // serial units
  logic          run_r, run_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   dsh_r, dsh_nxt;
  logic [9:0]    rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic          dneg_r, dneg_nxt;
  logic [QW-1:0] ma_r, ma_nxt, acc_hi_r, acc_hi_nxt, acc_lo_r, acc_lo_nxt;
  logic          mneg_r, mneg_nxt;

  logic      out_valid_r, out_valid_nxt;
  amdc_out_t out_data_r, out_data_nxt;

  logic accept, out_load, is_div, is_mul, done;
  logic [4:0]  steer_in;
  logic [3:0]  steer_k;
  logic signed [16:0] diff;
  logic [15:0] dmag_sel;
  logic        dneg_sel;
  logic signed [QW-1:0] mop_a, mop_b, prod_s, div_s, v_sig, steer_term;
  logic [2*QW-1:0] prod;
  logic [QW-1:0]   rmag;
  logic [10:0]     dtrial;
  logic [QW:0]     msum;
  logic            roll;
  logic [QW+7:0]   duty_w;
  logic [6:0]      duty;

  assign accept   = in_valid && !in_stall;
  assign out_load = !out_valid_r || !out_stall;
  assign is_div   = (state_r == ST_DSP) || (state_r == ST_DRF) || (state_r == ST_DERR);
  assign is_mul   = (state_r == ST_SIG1) || (state_r == ST_SIG2) || (state_r == ST_EE) ||
                    (state_r == ST_AD1) || (state_r == ST_AD2);
  assign done     = run_r && (cnt_r == (is_div ? DEND : MEND));
  assign steer_in = (in_data.steer_position > 5'd17) ? 5'd17 : in_data.steer_position;
  assign steer_k  = (steer_r > 5'd8) ? 4'(steer_r - 5'd9) : 4'(5'd9 - steer_r);
  assign diff     = $signed({1'b0, ss_r}) - $signed({1'b0, ref_r});

  // operand selection for the serial units
  always_comb begin
    dmag_sel = ss_r;
    dneg_sel = 1'b0;
    if (state_r == ST_DRF) begin
      dmag_sel = ref_r;
    end else if (state_r == ST_DERR) begin
      dneg_sel = diff[16];
      dmag_sel = diff[16] ? 16'(-diff) : diff[15:0];
    end
    mop_a = ee_r;
    mop_b = err_r;
    case (state_r)
      ST_SIG1: begin
        mop_a = use_neuron_r ? ws_r : wb_r;
        mop_b = use_neuron_r ? sp_r : err_r;
      end
      ST_SIG2: begin
        mop_a = use_neuron_r ? wt_r : ws_r;
        mop_b = use_neuron_r ? rf_r : es_r;
      end
      ST_EE: begin
        mop_a = QEPS;
        mop_b = err_r;
      end
      ST_AD1: mop_b = use_neuron_r ? sp_r : err_r;
      ST_AD2: mop_b = use_neuron_r ? rf_r : es_r;
      default: ;
    endcase
  end

  // finished unit results
  always_comb begin
    prod = {acc_hi_r, acc_lo_r};
    rmag = ((prod >> (FRAC_BITS + QW - 1)) != '0) ? {1'b1, {(QW-1){1'b0}}}
                                                  : QW'(prod >> FRAC_BITS);
    if (mneg_r) prod_s = -$signed(rmag);
    else        prod_s = rmag[QW-1] ? Q_MAX : $signed(rmag);
    div_s = dneg_r ? -$signed(q_r) : $signed(q_r);
    steer_term = sat_mul_small((steer_r > 5'd8) ? wl_r : wr_r, steer_k);
    v_sig = use_neuron_r ? sat_add(vacc_r, steer_term) : vacc_r;
    roll = ((before_r > QONE) && (v_sig > before_r)) ||
           ((before_r < 0) && (v_sig < before_r));
    duty_w = {8'd0, fin_r} * (QW+8)'(100);
    if (no_feedback_r)       duty = (ref_r > 16'd100) ? 7'd100 : ref_r[6:0];
    else if (fin_r > QONE)   duty = 7'd100;
    else if (fin_r < 0)      duty = 7'd0;
    else                     duty = 7'(duty_w >> FRAC_BITS);
    dtrial = {rem_r, dsh_r[15]};
    msum = {1'b0, acc_hi_r} + (acc_lo_r[0] ? {1'b0, ma_r} : {(QW+1){1'b0}});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_DSP;
      ST_DSP:  if (done) state_nxt = ST_DRF;
      ST_DRF:  if (done) state_nxt = ST_DERR;
      ST_DERR: if (done) state_nxt = ST_SIG1;
      ST_SIG1: if (done) state_nxt = ST_SIG2;
      ST_SIG2: if (done) state_nxt = ST_SIGF;
      ST_SIGF: begin
        if (pass_r == PS_BEFORE)      state_nxt = ST_EE;
        else if (pass_r == PS_AFTER && roll) state_nxt = ST_DSP;
        else                          state_nxt = ST_OUT;
      end
      ST_EE:   if (done) state_nxt = ST_AD1;
      ST_AD1:  if (done) state_nxt = ST_AD2;
      ST_AD2:  if (done) state_nxt = ST_SIG1;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pass_nxt = pass_r;
    ss_nxt = ss_r; wb_nxt = wb_r; wl_nxt = wl_r; wr_nxt = wr_r;
    ws_nxt = ws_r; wt_nxt = wt_r; es_nxt = es_r;
    sv_ss_nxt = sv_ss_r; sv_b_nxt = sv_b_r; sv_l_nxt = sv_l_r; sv_r_nxt = sv_r_r;
    sv_s_nxt = sv_s_r; sv_t_nxt = sv_t_r; sv_e_nxt = sv_e_r;
    vld_nxt = vld_r; ref_nxt = ref_r; steer_nxt = steer_r; rolled_nxt = rolled_r;
    sp_nxt = sp_r; rf_nxt = rf_r; err_nxt = err_r; ee_nxt = ee_r;
    vacc_nxt = vacc_r; before_nxt = before_r; fin_nxt = fin_r;
    run_nxt = run_r; cnt_nxt = cnt_r;
    dsh_nxt = dsh_r; rem_nxt = rem_r; q_nxt = q_r; dneg_nxt = dneg_r;
    ma_nxt = ma_r; acc_hi_nxt = acc_hi_r; acc_lo_nxt = acc_lo_r; mneg_nxt = mneg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;

    if ((is_div || is_mul) && !run_r) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dsh_nxt = dmag_sel;
      dneg_nxt = dneg_sel;
      rem_nxt = '0;
      q_nxt = '0;
      mneg_nxt = mop_a[QW-1] ^ mop_b[QW-1];
      ma_nxt = mop_a[QW-1] ? QW'(-mop_a) : mop_a;
      acc_lo_nxt = mop_b[QW-1] ? QW'(-mop_b) : mop_b;
      acc_hi_nxt = '0;
    end else if (run_r && !done) begin
      cnt_nxt = cnt_r + 1'b1;
      if (is_div) begin
        // restoring division by 1000, one quotient bit per cycle
        dsh_nxt = {dsh_r[14:0], 1'b0};
        if (dtrial >= 11'd1000) begin
          rem_nxt = 10'(dtrial - 11'd1000);
          q_nxt = {q_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = dtrial[9:0];
          q_nxt = {q_r[QW-2:0], 1'b0};
        end
      end else begin
        {acc_hi_nxt, acc_lo_nxt} = {msum, acc_lo_r[QW-1:1]};
      end
    end else if (done) begin
      run_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          vld_nxt = in_data.speed_valid;
          ref_nxt = in_data.speed_target;
          steer_nxt = steer_in;
          rolled_nxt = 1'b0;
          pass_nxt = in_data.speed_valid ? PS_BEFORE : PS_FINAL;
          if (in_data.speed_valid) begin
            sv_ss_nxt = ss_r; sv_b_nxt = wb_r; sv_l_nxt = wl_r; sv_r_nxt = wr_r;
            sv_s_nxt = ws_r; sv_t_nxt = wt_r; sv_e_nxt = es_r;
            ss_nxt = in_data.measured_speed;
          end
        end
      end
      ST_DSP:  if (done) sp_nxt = div_s;
      ST_DRF:  if (done) rf_nxt = div_s;
      ST_DERR: if (done) err_nxt = div_s;
      ST_SIG1: begin
        if (done) vacc_nxt = use_neuron_r ? sat_add(sat_sub('0, wb_r), prod_s) : prod_s;
      end
      ST_SIG2: if (done) vacc_nxt = sat_add(vacc_r, prod_s);
      ST_SIGF: begin
        if (pass_r == PS_BEFORE) begin
          before_nxt = v_sig;
        end else if (pass_r == PS_AFTER && roll) begin
          ss_nxt = sv_ss_r; wb_nxt = sv_b_r; wl_nxt = sv_l_r; wr_nxt = sv_r_r;
          ws_nxt = sv_s_r; wt_nxt = sv_t_r; es_nxt = sv_e_r;
          rolled_nxt = 1'b1;
          pass_nxt = PS_FINAL;
        end else begin
          fin_nxt = v_sig;
        end
      end
      ST_EE: begin
        if (done) begin
          ee_nxt = prod_s;
          if (use_neuron_r) begin
            wb_nxt = sat_add(wb_r, prod_s);
            if (steer_r > 5'd8) wl_nxt = sat_sub(wl_r, sat_mul_small(prod_s, steer_k));
            else                wr_nxt = sat_sub(wr_r, sat_mul_small(prod_s, steer_k));
          end else begin
            es_nxt = sat_add(es_r, err_r);
            wt_nxt = '0;
            wl_nxt = '0;
            wr_nxt = '0;
          end
        end
      end
      ST_AD1: begin
        if (done) begin
          if (use_neuron_r) ws_nxt = sat_sub(ws_r, prod_s);
          else              wb_nxt = sat_sub(wb_r, prod_s);
        end
      end
      ST_AD2: begin
        if (done) begin
          if (use_neuron_r) wt_nxt = sat_sub(wt_r, prod_s);
          else              ws_nxt = sat_sub(ws_r, prod_s);
          pass_nxt = PS_AFTER;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.motor_duty = duty;
          out_data_nxt.rolled_back = rolled_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r <= PS_FINAL;
      run_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      use_neuron_r <= 1'b0;
      no_feedback_r <= 1'b0;
      ss_r <= '0; wb_r <= '0; wl_r <= '0; wr_r <= '0;
      ws_r <= '0; wt_r <= '0; es_r <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (amdc_reg_t'(cfg_idx))
          REG_USE_NEURON:  use_neuron_r <= cfg_wdata;
          REG_NO_FEEDBACK: no_feedback_r <= cfg_wdata;
          default: ;
        endcase
      end
      ss_r <= ss_nxt; wb_r <= wb_nxt; wl_r <= wl_nxt; wr_r <= wr_nxt;
      ws_r <= ws_nxt; wt_r <= wt_nxt; es_r <= es_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sv_ss_r <= sv_ss_nxt; sv_b_r <= sv_b_nxt; sv_l_r <= sv_l_nxt; sv_r_r <= sv_r_nxt;
    sv_s_r <= sv_s_nxt; sv_t_r <= sv_t_nxt; sv_e_r <= sv_e_nxt;
    vld_r <= vld_nxt; ref_r <= ref_nxt; steer_r <= steer_nxt; rolled_r <= rolled_nxt;
    sp_r <= sp_nxt; rf_r <= rf_nxt; err_r <= err_nxt; ee_r <= ee_nxt;
    vacc_r <= vacc_nxt; before_r <= before_nxt; fin_r <= fin_nxt;
    dsh_r <= dsh_nxt; rem_r <= rem_nxt; q_r <= q_nxt; dneg_r <= dneg_nxt;
    ma_r <= ma_nxt; acc_hi_r <= acc_hi_nxt; acc_lo_r <= acc_lo_nxt; mneg_r <= mneg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after an input transaction");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (cnt_r <= (is_div ? DEND : MEND)))
    else $error("serial unit counter ran past its length");

  a_rollback_needs_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_load) |-> (!rolled_r || vld_r))
    else $error("rollback flagged on a transaction without measured speed");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.motor_duty <= 7'd100))
    else $error("duty above 100");

endmodule

`default_nettype wire
